[rtl/lcdns_pkg.sv]
`timescale 1ns / 1ps
package lcdns_pkg;

    localparam int MAX_SHIFT = 16;
    localparam int CNT_W     = $clog2(MAX_SHIFT + 1);
    localparam int PC_W      = 4;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_CURSOR = 2'd2,
        OP_SHIFT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        NS_CONST = 2'd0,
        NS_HIGH  = 2'd1,
        NS_LOW   = 2'd2
    } t_nib_sel;

    typedef enum logic [1:0] {
        SQ_NEXT = 2'd0,
        SQ_END  = 2'd1,
        SQ_LOOP = 2'd2
    } t_seq;

    typedef struct packed {
        t_nib_sel    nib_sel;
        logic [3:0]  nib;
        logic [5:0]  wait_ms;
        logic        use_rs;
        t_seq        seq;
    } t_uword;

    typedef struct packed {
        logic   emit;
        logic   last;
        t_uword uw;
    } t_step;

    localparam logic [PC_W-1:0] PC_INIT = 4'd0;
    localparam logic [PC_W-1:0] PC_BYTE = 4'd14;

    localparam logic [7:0] ROW0_BASE   = 8'h80;
    localparam logic [7:0] ROW1_BASE   = 8'hC0;
    localparam logic [7:0] SHIFT_RIGHT = 8'h14;
    localparam logic [7:0] SHIFT_LEFT  = 8'h10;

    function automatic t_uword uw_const(input logic [3:0] nib, input logic [5:0] wait_ms,
                                        input t_seq seq);
        t_uword w;
        w.nib_sel = NS_CONST;
        w.nib     = nib;
        w.wait_ms = wait_ms;
        w.use_rs  = 1'b0;
        w.seq     = seq;
        return w;
    endfunction

    function automatic t_uword uw_byte(input t_nib_sel sel, input t_seq seq);
        t_uword w;
        w.nib_sel = sel;
        w.nib     = 4'd0;
        w.wait_ms = 6'd0;
        w.use_rs  = 1'b1;
        w.seq     = seq;
        return w;
    endfunction

    // Microprogram: power-up run at 0..13, byte transfer loop at 14..15.
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = uw_const(4'h3, 6'd50, SQ_NEXT);
            4'd1:    w = uw_const(4'h3, 6'd10, SQ_NEXT);
            4'd2:    w = uw_const(4'h3, 6'd10, SQ_NEXT);
            4'd3:    w = uw_const(4'h2, 6'd12, SQ_NEXT);
            4'd4:    w = uw_const(4'h2, 6'd0,  SQ_NEXT);
            4'd5:    w = uw_const(4'h8, 6'd0,  SQ_NEXT);
            4'd6:    w = uw_const(4'h0, 6'd0,  SQ_NEXT);
            4'd7:    w = uw_const(4'h8, 6'd0,  SQ_NEXT);
            4'd8:    w = uw_const(4'h0, 6'd0,  SQ_NEXT);
            4'd9:    w = uw_const(4'h1, 6'd0,  SQ_NEXT);
            4'd10:   w = uw_const(4'h0, 6'd0,  SQ_NEXT);
            4'd11:   w = uw_const(4'h6, 6'd0,  SQ_NEXT);
            4'd12:   w = uw_const(4'h0, 6'd0,  SQ_NEXT);
            4'd13:   w = uw_const(4'hF, 6'd0,  SQ_END);
            4'd14:   w = uw_byte(NS_HIGH, SQ_NEXT);
            4'd15:   w = uw_byte(NS_LOW,  SQ_LOOP);
            default: w = uw_const(4'h0, 6'd0, SQ_END);
        endcase
        return w;
    endfunction

endpackage

[rtl/lcdns_sequencer.sv]
`timescale 1ns / 1ps
module lcdns_sequencer import lcdns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_op,
    input  logic signed [5:0] i_shift_steps,
    input  logic              i_slot_free,
    output logic              o_busy,
    output t_step             o_step
);

    localparam logic signed [6:0] SAT_HI = 7'(MAX_SHIFT);
    localparam logic signed [6:0] SAT_LO = -7'(MAX_SHIFT);

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic [CNT_W-1:0] r_count, n_count;

    logic              accept;
    logic              start;
    logic signed [6:0] steps;
    logic [CNT_W-1:0]  mag;
    t_uword            uw;
    logic              emit;
    logic              cnt_one;

    assign accept = i_in_valid && !r_busy;

    // clamp to +/-MAX_SHIFT, then take magnitude
    always_comb begin
        steps = 7'(i_shift_steps);
        if (steps > SAT_HI) begin
            mag = CNT_W'(MAX_SHIFT);
        end else if (steps < SAT_LO) begin
            mag = CNT_W'(MAX_SHIFT);
        end else if (steps < 0) begin
            mag = CNT_W'(-steps);
        end else begin
            mag = CNT_W'(steps);
        end
    end

    // a zero shift produces no beats at all
    assign start   = accept && !(t_op'(i_op) == OP_SHIFT && mag == '0);
    assign uw      = ucode(r_pc);
    assign emit    = r_busy && i_slot_free;
    assign cnt_one = (r_count == CNT_W'(1));

    always_comb begin
        n_busy  = r_busy;
        n_pc    = r_pc;
        n_count = r_count;
        if (start) begin
            n_busy  = 1'b1;
            n_pc    = (t_op'(i_op) == OP_INIT) ? PC_INIT : PC_BYTE;
            n_count = (t_op'(i_op) == OP_SHIFT) ? mag : CNT_W'(1);
        end else if (emit) begin
            case (uw.seq)
                SQ_NEXT: n_pc = r_pc + PC_W'(1);
                SQ_END:  n_busy = 1'b0;
                SQ_LOOP: begin
                    if (cnt_one) begin
                        n_busy = 1'b0;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_pc    = PC_BYTE;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= PC_INIT;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_pc    <= n_pc;
            r_count <= n_count;
        end
    end

    assign o_busy      = r_busy;
    assign o_step.emit = emit;
    assign o_step.last = (uw.seq == SQ_END) || (uw.seq == SQ_LOOP && cnt_one);
    assign o_step.uw   = uw;

endmodule

[rtl/lcdns_datapath.sv]
`timescale 1ns / 1ps
module lcdns_datapath import lcdns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [1:0]        i_op,
    input  logic              i_register_select,
    input  logic [7:0]        i_byte_value,
    input  logic [3:0]        i_column,
    input  logic              i_row,
    input  logic signed [5:0] i_shift_steps,
    input  t_step             i_step,
    input  logic              i_out_stall,
    output logic              o_slot_free,
    output logic              o_out_valid,
    output logic              o_rs_level,
    output logic [3:0]        o_nibble,
    output logic [5:0]        o_wait_before_ms,
    output logic              o_last
);

    logic [7:0] r_byte, n_byte;
    logic       r_rs, n_rs;
    logic       r_out_valid;
    logic       r_rs_level;
    logic [3:0] r_nibble, n_nibble;
    logic [5:0] r_wait;
    logic       r_last;

    always_comb begin
        n_byte = 8'h00;
        n_rs   = 1'b0;
        case (t_op'(i_op))
            OP_WRITE: begin
                n_byte = i_byte_value;
                n_rs   = i_register_select;
            end
            OP_CURSOR: n_byte = (i_row ? ROW1_BASE : ROW0_BASE) | {4'h0, i_column};
            OP_SHIFT:  n_byte = i_shift_steps[5] ? SHIFT_LEFT : SHIFT_RIGHT;
            default:   n_byte = 8'h00;
        endcase
    end

    always_comb begin
        case (i_step.uw.nib_sel)
            NS_CONST: n_nibble = i_step.uw.nib;
            NS_HIGH:  n_nibble = r_byte[7:4];
            NS_LOW:   n_nibble = r_byte[3:0];
            default:  n_nibble = 4'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= n_byte;
            r_rs   <= n_rs;
        end
        if (i_step.emit) begin
            r_rs_level <= i_step.uw.use_rs & r_rs;
            r_nibble   <= n_nibble;
            r_wait     <= i_step.uw.wait_ms;
            r_last     <= i_step.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_slot_free      = !r_out_valid || !i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_rs_level       = r_rs_level;
    assign o_nibble         = r_nibble;
    assign o_wait_before_ms = r_wait;
    assign o_last           = r_last;

endmodule

[rtl/char_lcd_nibble_sequencer_unit.sv]
`timescale 1ns / 1ps
// Path: the sequencer registers an accepted command, then the output register holds
// each nibble beat. Throughput: one nibble beat per cycle from the microprogram step
// counter while the output is not stalled; a command holds the input stalled until
// its last nibble has been emitted (a shift emits up to 16 steps).
// Reset (synchronous, active low) idles the sequencer and empties the output register.
module char_lcd_nibble_sequencer_unit import lcdns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_op,
    input  logic              i_register_select,
    input  logic [7:0]        i_byte_value,
    input  logic [3:0]        i_column,
    input  logic              i_row,
    input  logic signed [5:0] i_shift_steps,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_rs_level,
    output logic [3:0]        o_nibble,
    output logic [5:0]        o_wait_before_ms,
    output logic              o_last
);

    // phase delay only sets strobe timing in the bus driver downstream;
    // it changes no field of a nibble beat, so nothing here holds it.

    logic  busy;
    logic  slot_free;
    t_step step;

    lcdns_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_op          (i_op),
        .i_shift_steps (i_shift_steps),
        .i_slot_free   (slot_free),
        .o_busy        (busy),
        .o_step        (step)
    );

    lcdns_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (i_in_valid && !busy),
        .i_op              (i_op),
        .i_register_select (i_register_select),
        .i_byte_value      (i_byte_value),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_shift_steps     (i_shift_steps),
        .i_step            (step),
        .i_out_stall       (i_out_stall),
        .o_slot_free       (slot_free),
        .o_out_valid       (o_out_valid),
        .o_rs_level        (o_rs_level),
        .o_nibble          (o_nibble),
        .o_wait_before_ms  (o_wait_before_ms),
        .o_last            (o_last)
    );

    assign o_in_stall = busy;

endmodule

[dv/char_lcd_nibble_sequencer_unit_test.sv]
`timescale 1ns / 1ps
module char_lcd_nibble_sequencer_unit_test;
    import lcdns_pkg::*;

    typedef struct {
        t_op               op;
        logic              rs;
        logic [7:0]        byte_val;
        logic [3:0]        col;
        logic              row;
        logic signed [5:0] steps;
    } t_lcd_cmd;

    typedef struct {
        logic       rs;
        logic [3:0] nib;
        logic [5:0] wait_ms;
        logic       last;
    } t_nib_beat;

    localparam logic [3:0] INIT_NIBS [14] = '{4'h3, 4'h3, 4'h3, 4'h2, 4'h2, 4'h8, 4'h0,
                                              4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hF};
    localparam logic [5:0] INIT_WAITS [14] = '{6'd50, 6'd10, 6'd10, 6'd12, 6'd0, 6'd0, 6'd0,
                                               6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [3:0]        i_cfg_data = 4'd0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_op = OP_INIT;
    logic              i_register_select = 1'b0;
    logic [7:0]        i_byte_value = 8'd0;
    logic [3:0]        i_column = 4'd0;
    logic              i_row = 1'b0;
    logic signed [5:0] i_shift_steps = 6'sd0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_rs_level;
    logic [3:0]        o_nibble;
    logic [5:0]        o_wait_before_ms;
    logic              o_last;

    t_nib_beat expected_nibbles[$];
    int        n_errors = 0;
    int        n_cmds = 0;
    int        n_beats = 0;
    int        n_cfg = 0;
    bit        src_idle = 1'b1;
    bit        sink_idle = 1'b1;
    int        sink_hold = 0;

    char_lcd_nibble_sequencer_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_register_select (i_register_select),
        .i_byte_value      (i_byte_value),
        .i_column          (i_column),
        .i_row             (i_row),
        .i_shift_steps     (i_shift_steps),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_rs_level        (o_rs_level),
        .o_nibble          (o_nibble),
        .o_wait_before_ms  (o_wait_before_ms),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic t_nib_beat make_beat(input logic rs, input logic [3:0] nib,
                                            input logic [5:0] wait_ms);
        t_nib_beat b;
        b.rs      = rs;
        b.nib     = nib;
        b.wait_ms = wait_ms;
        b.last    = 1'b0;
        return b;
    endfunction

    // Expand one command into its nibble run and queue it.
    function automatic void predict_nibbles(input t_lcd_cmd c);
        t_nib_beat  run[$];
        int         i;
        int         reps;
        int         count;
        logic       rs;
        logic [7:0] code;
        reps = 0;
        rs   = 1'b0;
        code = 8'd0;
        case (c.op)
            OP_INIT: begin
                for (i = 0; i < 14; i++)
                    run.push_back(make_beat(1'b0, INIT_NIBS[i], INIT_WAITS[i]));
            end
            OP_WRITE: begin
                reps = 1;
                rs   = c.rs;
                code = c.byte_val;
            end
            OP_CURSOR: begin
                reps = 1;
                code = (c.row ? ROW1_BASE : ROW0_BASE) | {4'd0, c.col};
            end
            default: begin
                count = c.steps;
                if (count > MAX_SHIFT) count = MAX_SHIFT;
                if (count < -MAX_SHIFT) count = -MAX_SHIFT;
                code = (count < 0) ? SHIFT_LEFT : SHIFT_RIGHT;
                reps = (count < 0) ? -count : count;
            end
        endcase
        for (i = 0; i < reps; i++) begin
            run.push_back(make_beat(rs, code[7:4], 6'd0));
            run.push_back(make_beat(rs, code[3:0], 6'd0));
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[j])
            expected_nibbles.push_back(run[j]);
    endfunction

    // Output side: check each accepted beat, then draw a stall for the next one.
    always @(posedge i_clk) begin
        t_nib_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_beats++;
            if (expected_nibbles.size() == 0) begin
                $display("%0t: unexpected beat rs=%0b nib=%h wait=%0d last=%0b", $time,
                         o_rs_level, o_nibble, o_wait_before_ms, o_last);
                n_errors++;
            end else begin
                want = expected_nibbles.pop_front();
                if (o_rs_level !== want.rs || o_nibble !== want.nib ||
                    o_wait_before_ms !== want.wait_ms || o_last !== want.last) begin
                    $display("%0t: mismatch expected rs=%0b nib=%h wait=%0d last=%0b",
                             $time, want.rs, want.nib, want.wait_ms, want.last);
                    $display("%0t:            actual rs=%0b nib=%h wait=%0d last=%0b",
                             $time, o_rs_level, o_nibble, o_wait_before_ms, o_last);
                    n_errors++;
                end
            end
            sink_hold = sink_idle ? $urandom_range(0, 6) : 0;
        end else if (sink_hold > 0) begin
            sink_hold--;
        end
        i_out_stall <= (sink_hold != 0);
    end

    function automatic t_lcd_cmd rand_cmd();
        t_lcd_cmd c;
        int       sel;
        sel        = $urandom_range(0, 99);
        c.op       = (sel < 8) ? OP_INIT : (sel < 45) ? OP_WRITE :
                     (sel < 65) ? OP_CURSOR : OP_SHIFT;
        c.rs       = 1'($urandom_range(0, 1));
        c.byte_val = 8'($urandom_range(0, 255));
        c.col      = 4'($urandom_range(0, 15));
        c.row      = 1'($urandom_range(0, 1));
        // mostly short shifts, sometimes anything the 6-bit field holds
        if ($urandom_range(0, 3) == 0)
            c.steps = 6'($urandom_range(0, 63));
        else
            c.steps = 6'(int'($urandom_range(0, 8)) - 4);
        return c;
    endfunction

    task automatic send_cmd(input t_lcd_cmd c);
        int gap;
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op              <= c.op;
        i_register_select <= c.rs;
        i_byte_value      <= c.byte_val;
        i_column          <= c.col;
        i_row             <= c.row;
        i_shift_steps     <= c.steps;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_nibbles(c);
        n_cmds++;
    endtask

    // Zero shifts leave nothing queued, so allow some slack after the queue drains.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_nibbles.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_phase_delay(input logic [3:0] ms);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= ms;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_cfg++;
    endtask

    task automatic send_write(input logic rs, input logic [7:0] b);
        t_lcd_cmd c;
        c          = rand_cmd();
        c.op       = OP_WRITE;
        c.rs       = rs;
        c.byte_val = b;
        send_cmd(c);
    endtask

    task automatic send_cursor(input logic row, input logic [3:0] col);
        t_lcd_cmd c;
        c     = rand_cmd();
        c.op  = OP_CURSOR;
        c.row = row;
        c.col = col;
        send_cmd(c);
    endtask

    task automatic send_shift(input logic signed [5:0] steps);
        t_lcd_cmd c;
        c       = rand_cmd();
        c.op    = OP_SHIFT;
        c.steps = steps;
        send_cmd(c);
    endtask

    task automatic test_directed();
        t_lcd_cmd c;
        c    = rand_cmd();
        c.op = OP_INIT;
        send_cmd(c);
        send_write(1'b0, 8'h00);
        send_write(1'b1, 8'hFF);
        send_write(1'b0, 8'hA5);
        send_write(1'b1, 8'h5A);
        send_cursor(1'b0, 4'd0);
        send_cursor(1'b1, 4'd15);
        send_cursor(1'b0, 4'd15);
        send_cursor(1'b1, 4'd0);
        send_shift(6'sd1);
        send_shift(-6'sd1);
        send_shift(6'sd16);
        send_shift(-6'sd16);
        // beyond the limit: clamps to 16 steps
        send_shift(6'sd17);
        send_shift(-6'sd17);
        send_shift(6'sd31);
        send_shift(-6'sd32);
        // zero shift emits nothing
        send_shift(6'sd0);
        send_shift(6'sd2);
        send_cmd(c);
    endtask

    task automatic test_random_phase(input int n, input logic [3:0] ms,
                                     input bit src_gaps, input bit sink_gaps);
        int k;
        set_phase_delay(ms);
        src_idle  = src_gaps;
        sink_idle = sink_gaps;
        for (k = 0; k < n; k++)
            send_cmd(rand_cmd());
    endtask

    task automatic test_drain_pause();
        int k;
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        for (k = 0; k < 20; k++) begin
            send_cmd(rand_cmd());
            if (k % 5 == 4)
                wait_idle();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_phase_delay(4'd1);
        test_directed();
        test_random_phase(70, 4'd15, 1'b1, 1'b1);
        test_random_phase(70, 4'($urandom_range(1, 15)), 1'b0, 1'b1);
        test_drain_pause();
        test_random_phase(70, 4'd8, 1'b1, 1'b0);
        test_random_phase(50, 4'd7, 1'b0, 1'b0);
        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Ran %0d commands (init, byte writes, cursor moves, shifts incl. clamp and zero)",
                 n_cmds);
        $display("Checked %0d nibble beats over %0d phase delay settings with random gaps",
                 n_beats, n_cfg);
        if (n_errors == 0 && expected_nibbles.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/lcdns_pkg.sv
rtl/lcdns_sequencer.sv
rtl/lcdns_datapath.sv
rtl/char_lcd_nibble_sequencer_unit.sv
dv/char_lcd_nibble_sequencer_unit_test.sv
